// ----- design/swept_aabb_collision_top_macros.svh -----
`ifndef SWEPT_AABB_COLLISION_TOP_MACROS_SVH
`define SWEPT_AABB_COLLISION_TOP_MACROS_SVH

// check prop on every rising clk edge outside reset
`define SWA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that cond never holds outside reset
`define SWA_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- design/swa_pkg.sv -----
package swa_pkg;

	localparam int CW       = 24;
	localparam int TF       = 16;
	localparam int OUT_TF   = 16;
	localparam int LANES    = 4;
	localparam int HW       = CW - 2;
	localparam int VW       = CW + 1;
	localparam int NUM_W    = CW + 2;
	localparam int MAG_W    = CW + 1;
	localparam int QB       = TF + 2;
	localparam int REM_W    = MAG_W + QB;
	localparam int TW       = TF + 4;
	localparam int ET_W     = OUT_TF + 1;
	localparam int SH_R     = (TF >= OUT_TF) ? TF - OUT_TF : 0;
	localparam int SH_L     = (TF < OUT_TF) ? OUT_TF - TF : 0;
	localparam int IN_RAW   = 12 * CW - 8;
	localparam int IN_W     = ((IN_RAW + 7) / 8) * 8;
	localparam int OUT_RAW  = 1 + ET_W + 4;
	localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;

	localparam logic signed [TW-1:0] T_SAT = TW'(2) <<< TF;
	localparam logic signed [TW-1:0] T_ONE = TW'(1) <<< TF;
	localparam logic [ET_W-1:0] ET_MISS = ET_W'(1) << OUT_TF;

	localparam logic signed [1:0] NRM_NONE = 2'sb00;
	localparam logic signed [1:0] NRM_POS  = 2'sb01;
	localparam logic signed [1:0] NRM_NEG  = 2'sb11;

	localparam int L_NX = 0;
	localparam int L_NY = 1;
	localparam int L_FX = 2;
	localparam int L_FY = 3;

	typedef struct packed {
		logic signed [CW-1:0] b_vel_y;
		logic signed [CW-1:0] b_vel_x;
		logic [HW-1:0]        b_half_height;
		logic [HW-1:0]        b_half_width;
		logic signed [CW-1:0] b_center_y;
		logic signed [CW-1:0] b_center_x;
		logic signed [CW-1:0] a_vel_y;
		logic signed [CW-1:0] a_vel_x;
		logic [HW-1:0]        a_half_height;
		logic [HW-1:0]        a_half_width;
		logic signed [CW-1:0] a_center_y;
		logic signed [CW-1:0] a_center_x;
	} in_t;

	typedef struct packed {
		logic       nan;
		logic       vneg_x;
		logic       vneg_y;
	} side_t;

	typedef struct packed {
		logic [MAG_W-1:0] num;
		logic [MAG_W-1:0] den;
		logic             neg;
	} divin_t;

	typedef struct packed {
		logic [QB-1:0] quo;
		logic          rem_nz;
		logic          neg;
		logic          ovf;
	} divout_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [MAG_W-1:0] den;
		logic [QB-1:0]    quo;
		logic             neg;
		logic             ovf;
	} divst_t;

endpackage

// ----- design/swept_aabb_collision_top.sv -----
// Swept box-pair collision test, one box pair per beat.
// s_* channel: one beat carries both boxes (centre, half extents, displacement).
// m_* channel: one beat per input beat, in order: hit, entry time, normal.
// Stages: two setup stages, a 19-stage restoring divider and three result
// stages. Throughput: one beat per cycle while m_tready is high; the divider
// retires one quotient bit per step stage for all four slab quotients in
// parallel, so nothing iterates.
// Each stage has its own valid bit and ready; bubbles close up, so the block
// keeps accepting input while a result waits on m_tready, until every stage
// holds a beat. A stall holds only full stages; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and s_tready is high
// right after reset.
// Missed pairs and 0/0 slabs give hit 0, entry time 65536, normals 0.
`include "swept_aabb_collision_top_macros.svh"

module swept_aabb_collision_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// a_center_x, a_center_y, a_half_width, a_half_height, a_vel_x, a_vel_y,
	// b_center_x, b_center_y, b_half_width, b_half_height, b_vel_x, b_vel_y
	input  logic [swa_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// hit, entry_time, normal_x, normal_y, zero pad
	output logic [swa_pkg::OUT_W-1:0]  m_tdata
);
	import swa_pkg::*;

	in_t in_d;
	assign in_d = in_t'(s_tdata[IN_RAW-1:0]);

	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic div_in_ready, div_out_valid;

	// stage 1: relative motion and slab numerators
	logic                    v_s1;
	logic signed [NUM_W-1:0] num_s1[LANES];
	logic signed [VW-1:0]    vx_s1, vy_s1;

	logic signed [VW-1:0]    vx_d, vy_d;
	logic [HW:0]             hx_d, hy_d;
	always_comb begin
		vx_d = VW'(in_d.a_vel_x) - VW'(in_d.b_vel_x);
		vy_d = VW'(in_d.a_vel_y) - VW'(in_d.b_vel_y);
		hx_d = {1'b0, in_d.a_half_width} + {1'b0, in_d.b_half_width};
		hy_d = {1'b0, in_d.a_half_height} + {1'b0, in_d.b_half_height};
	end

	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			num_s1[L_NX] <= NUM_W'(in_d.b_center_x) - signed'(NUM_W'(hx_d))
				- NUM_W'(in_d.a_center_x);
			num_s1[L_FX] <= NUM_W'(in_d.b_center_x) + signed'(NUM_W'(hx_d))
				- NUM_W'(in_d.a_center_x);
			num_s1[L_NY] <= NUM_W'(in_d.b_center_y) - signed'(NUM_W'(hy_d))
				- NUM_W'(in_d.a_center_y);
			num_s1[L_FY] <= NUM_W'(in_d.b_center_y) + signed'(NUM_W'(hy_d))
				- NUM_W'(in_d.a_center_y);
			vx_s1 <= vx_d;
			vy_s1 <= vy_d;
		end
	end

	// stage 2: magnitudes and signs
	logic                       v_s2;
	divin_t [LANES-1:0]         dv_s2;
	side_t                      side_s2;

	divin_t [LANES-1:0]         dv_d;
	side_t                      side_d;
	always_comb begin
		logic signed [VW-1:0] den;
		logic                 z;
		z = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			den = (l == L_NX || l == L_FX) ? vx_s1 : vy_s1;
			dv_d[l].num = num_s1[l][NUM_W-1] ? MAG_W'(-num_s1[l]) : MAG_W'(num_s1[l]);
			dv_d[l].den = den[VW-1] ? MAG_W'(-den) : MAG_W'(den);
			dv_d[l].neg = num_s1[l][NUM_W-1] ^ den[VW-1];
			z = z | ((num_s1[l] == '0) && (den == '0));
		end
		side_d.nan    = z;
		side_d.vneg_x = vx_s1[VW-1];
		side_d.vneg_y = vy_s1[VW-1];
	end

	assign rdy2 = !v_s2 || div_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			dv_s2   <= dv_d;
			side_s2 <= side_d;
		end
	end

	divout_t [LANES-1:0] dq;
	side_t               dside;

	swa_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.in_data   (dv_s2),
		.in_side   (side_s2),
		.out_valid (div_out_valid),
		.out_ready (rdy3),
		.out_data  (dq),
		.out_side  (dside)
	);

	// stage 3: signed, floored and saturated times
	logic                 v_s3;
	logic signed [TW-1:0] t_s3[LANES];
	side_t                side_s3;

	logic signed [TW-1:0] t_d[LANES];
	always_comb begin
		logic signed [TW-1:0] q;
		for (int l = 0; l < LANES; l++) begin
			q = signed'(TW'(dq[l].quo));
			if (dq[l].ovf) begin
				t_d[l] = dq[l].neg ? -T_SAT : T_SAT;
			end else if (dq[l].neg) begin
				t_d[l] = -q - signed'(TW'(dq[l].rem_nz));
				if (t_d[l] < -T_SAT) begin
					t_d[l] = -T_SAT;
				end
			end else begin
				t_d[l] = (q > T_SAT) ? T_SAT : q;
			end
		end
	end

	assign rdy3 = !v_s3 || rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && div_out_valid) begin
			t_s3    <= t_d;
			side_s3 <= dside;
		end
	end

	// stage 4: order entry and exit per axis
	logic                 v_s4;
	logic signed [TW-1:0] nx_s4, ny_s4, fx_s4, fy_s4;
	side_t                side_s4;

	assign rdy4 = !v_s4 || rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			nx_s4   <= (t_s3[L_NX] > t_s3[L_FX]) ? t_s3[L_FX] : t_s3[L_NX];
			fx_s4   <= (t_s3[L_NX] > t_s3[L_FX]) ? t_s3[L_NX] : t_s3[L_FX];
			ny_s4   <= (t_s3[L_NY] > t_s3[L_FY]) ? t_s3[L_FY] : t_s3[L_NY];
			fy_s4   <= (t_s3[L_NY] > t_s3[L_FY]) ? t_s3[L_NY] : t_s3[L_FY];
			side_s4 <= side_s3;
		end
	end

	// stage 5: overlap test and result register
	logic                 v_s5;
	logic                 hit_s5;
	logic [ET_W-1:0]      et_s5;
	logic signed [1:0]    nrmx_s5, nrmy_s5;

	logic                 hit_d;
	logic [ET_W-1:0]      et_d;
	logic signed [1:0]    nrmx_d, nrmy_d;
	always_comb begin
		logic                 x_last;
		logic signed [TW-1:0] t;
		x_last = nx_s4 > ny_s4;
		t      = x_last ? nx_s4 : ny_s4;
		hit_d  = !side_s4.nan && !(nx_s4 >= fy_s4) && !(ny_s4 >= fx_s4)
			&& !(t >= T_ONE) && !(t < 0);
		if (TF >= OUT_TF) begin
			et_d = ET_W'(t >>> SH_R);
		end else begin
			et_d = ET_W'(t <<< SH_L);
		end
		nrmx_d = NRM_NONE;
		nrmy_d = NRM_NONE;
		if (!hit_d) begin
			et_d = ET_MISS;
		end else if (x_last) begin
			nrmx_d = side_s4.vneg_x ? NRM_POS : NRM_NEG;
		end else begin
			nrmy_d = side_s4.vneg_y ? NRM_POS : NRM_NEG;
		end
	end

	assign rdy5 = !v_s5 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			hit_s5  <= hit_d;
			et_s5   <= et_d;
			nrmx_s5 <= nrmx_d;
			nrmy_s5 <= nrmy_d;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = OUT_W'({nrmy_s5, nrmx_s5, et_s5, hit_s5});

	`SWA_ASSERT(a_hit_time, (v_s5 && hit_s5) |-> (et_s5 < ET_MISS),
		"hit with entry time outside the step")
	`SWA_ASSERT(a_miss_fields,
		(v_s5 && !hit_s5) |-> (et_s5 == ET_MISS && nrmx_s5 == NRM_NONE && nrmy_s5 == NRM_NONE),
		"miss result with nonzero fields")
	`SWA_ASSERT(a_one_normal, (v_s5 && hit_s5) |-> ((nrmx_s5 != NRM_NONE) != (nrmy_s5 != NRM_NONE)),
		"hit must carry exactly one axis normal")
	`SWA_NEVER(a_time_range, v_s3 && (t_s3[L_NX] > T_SAT || t_s3[L_NX] < -T_SAT),
		"slab time outside saturation bounds")

endmodule

// ----- design/swa_div_pipe.sv -----
module swa_div_pipe (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  swa_pkg::divin_t [swa_pkg::LANES-1:0]  in_data,
	input  swa_pkg::side_t                        in_side,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output swa_pkg::divout_t [swa_pkg::LANES-1:0] out_data,
	output swa_pkg::side_t                        out_side
);
	import swa_pkg::*;

	logic                    vld_s [QB+1];
	divst_t [LANES-1:0]      st_s  [QB+1];
	side_t                   side_s[QB+1];
	logic                    rdy   [QB+2];

	assign rdy[QB+1] = out_ready;
	for (genvar k = 0; k <= QB; k++) begin : g_rdy
		assign rdy[k] = !vld_s[k] || rdy[k+1];
	end
	assign in_ready = rdy[0];

	divst_t [LANES-1:0] init_d;
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			init_d[l].ovf = ({2'b00, in_data[l].num} >= {in_data[l].den, 2'b00});
			init_d[l].rem = REM_W'(in_data[l].num) << TF;
			init_d[l].den = in_data[l].den;
			init_d[l].quo = '0;
			init_d[l].neg = in_data[l].neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			st_s[0]   <= init_d;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		divst_t [LANES-1:0] nxt;
		always_comb begin
			logic [REM_W-1:0] sh;
			nxt = st_s[k-1];
			for (int l = 0; l < LANES; l++) begin
				sh = REM_W'(nxt[l].den) << (QB - k);
				if (nxt[l].rem >= sh) begin
					nxt[l].rem        = nxt[l].rem - sh;
					nxt[l].quo[QB-k] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld_s[k-1]) begin
				st_s[k]   <= nxt;
				side_s[k] <= side_s[k-1];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			out_data[l].quo    = st_s[QB][l].quo;
			out_data[l].rem_nz = |st_s[QB][l].rem;
			out_data[l].neg    = st_s[QB][l].neg;
			out_data[l].ovf    = st_s[QB][l].ovf;
		end
	end
	assign out_valid = vld_s[QB];
	assign out_side  = side_s[QB];

endmodule

// ----- verif/tb_swept_aabb_collision_top.sv -----
`timescale 1ns / 100ps

module tb_swept_aabb_collision_top;
	import swa_pkg::*;

	typedef struct packed {
		logic signed [1:0] normal_y;
		logic signed [1:0] normal_x;
		logic [ET_W-1:0]   entry_time;
		logic              hit;
	} hit_t;

	localparam int N_RAND   = 1830;
	localparam int WD_LIMIT = 2000;
	localparam int N_DIR    = 16;
	localparam int CHK_NONE = 0;
	localparam int CHK_MISS = 1;
	localparam int CHK_TYPED = 2;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;

	hit_t expected_hits[$];
	int errors;
	int idle_cycles;
	bit quiet;
	bit hold_off_req;

	swept_aabb_collision_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit slab_div(input longint num, input longint den, output longint q);
		longint n;
		longint tsat;
		tsat = longint'(2) << TF;
		if (den == 0) begin
			if (num == 0)
				return 0;
			q = num > 0 ? tsat : -tsat;
			return 1;
		end
		n = num * (longint'(1) << TF);
		q = n / den;
		if ((n % den != 0) && ((n < 0) != (den < 0)))
			q = q - 1;
		if (q > tsat)
			q = tsat;
		if (q < -tsat)
			q = -tsat;
		return 1;
	endfunction

	function automatic hit_t sweep_hit(input in_t p);
		hit_t r;
		longint vx, vy, hx, hy, nx, ny, fx, fy, t, tmp;
		bit ok;
		r.hit = 1'b0;
		r.entry_time = ET_MISS;
		r.normal_x = NRM_NONE;
		r.normal_y = NRM_NONE;
		vx = longint'(p.a_vel_x) - longint'(p.b_vel_x);
		vy = longint'(p.a_vel_y) - longint'(p.b_vel_y);
		hx = longint'(p.a_half_width) + longint'(p.b_half_width);
		hy = longint'(p.a_half_height) + longint'(p.b_half_height);
		ok = slab_div(longint'(p.b_center_x) - hx - longint'(p.a_center_x), vx, nx);
		ok = slab_div(longint'(p.b_center_y) - hy - longint'(p.a_center_y), vy, ny) && ok;
		ok = slab_div(longint'(p.b_center_x) + hx - longint'(p.a_center_x), vx, fx) && ok;
		ok = slab_div(longint'(p.b_center_y) + hy - longint'(p.a_center_y), vy, fy) && ok;
		if (!ok)
			return r;
		if (nx > fx) begin
			tmp = nx; nx = fx; fx = tmp;
		end
		if (ny > fy) begin
			tmp = ny; ny = fy; fy = tmp;
		end
		if (nx >= fy || ny >= fx)
			return r;
		t = nx > ny ? nx : ny;
		if (t >= (longint'(1) << TF) || t < 0)
			return r;
		r.hit = 1'b1;
		r.entry_time = ET_W'((t >>> SH_R) << SH_L);
		if (nx > ny) begin
			r.normal_x = vx < 0 ? NRM_POS : NRM_NEG;
		end else begin
			r.normal_y = vy < 0 ? NRM_POS : NRM_NEG;
		end
		return r;
	endfunction

	function automatic in_t box_pair(input int acx, acy, ahw, ahh, avx, avy,
			input int bcx, bcy, bhw, bhh, bvx, bvy);
		in_t p;
		p.a_center_x = CW'(acx); p.a_center_y = CW'(acy);
		p.a_half_width = HW'(ahw); p.a_half_height = HW'(ahh);
		p.a_vel_x = CW'(avx); p.a_vel_y = CW'(avy);
		p.b_center_x = CW'(bcx); p.b_center_y = CW'(bcy);
		p.b_half_width = HW'(bhw); p.b_half_height = HW'(bhh);
		p.b_vel_x = CW'(bvx); p.b_vel_y = CW'(bvy);
		return p;
	endfunction

	function automatic in_t random_pair(input bit near);
		in_t p;
		int span;
		p = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom});
		if (near) begin
			span = 1 << $urandom_range(6, 20);
			p.a_center_x = CW'($signed($urandom_range(0, 2 * span)) - span);
			p.a_center_y = CW'($signed($urandom_range(0, 2 * span)) - span);
			p.b_center_x = CW'($signed($urandom_range(0, 2 * span)) - span);
			p.b_center_y = CW'($signed($urandom_range(0, 2 * span)) - span);
			p.a_half_width = HW'($urandom_range(0, span / 2));
			p.a_half_height = HW'($urandom_range(0, span / 2));
			p.b_half_width = HW'($urandom_range(0, span / 2));
			p.b_half_height = HW'($urandom_range(0, span / 2));
			p.a_vel_x = CW'($signed($urandom_range(0, 4 * span)) - 2 * span);
			p.a_vel_y = CW'($signed($urandom_range(0, 4 * span)) - 2 * span);
			p.b_vel_x = ($urandom_range(0, 3) == 0) ? p.a_vel_x
				: CW'($signed($urandom_range(0, 2 * span)) - span);
			p.b_vel_y = ($urandom_range(0, 3) == 0) ? p.a_vel_y
				: CW'($signed($urandom_range(0, 2 * span)) - span);
		end
		return p;
	endfunction

	task automatic send_pair(input in_t p, input int chk, input hit_t typed);
		hit_t exp_r;
		exp_r = sweep_hit(p);
		if (chk == CHK_MISS) begin
			exp_r.hit = 1'b0; exp_r.entry_time = ET_MISS;
			exp_r.normal_x = NRM_NONE; exp_r.normal_y = NRM_NONE;
		end else if (chk == CHK_TYPED) begin
			exp_r = typed;
		end
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'(p);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_hits.push_back(exp_r);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		hit_t got, exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = hit_t'(m_tdata[OUT_RAW-1:0]);
			if (expected_hits.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				exp_r = expected_hits.pop_front();
				if (got.hit !== exp_r.hit) begin
					$error("hit exp %0d got %0d", exp_r.hit, got.hit);
					errors++;
				end
				if (got.entry_time !== exp_r.entry_time) begin
					$error("entry_time exp %0d got %0d", exp_r.entry_time, got.entry_time);
					errors++;
				end
				if (got.normal_x !== exp_r.normal_x) begin
					$error("normal_x exp %0d got %0d", exp_r.normal_x, got.normal_x);
					errors++;
				end
				if (got.normal_y !== exp_r.normal_y) begin
					$error("normal_y exp %0d got %0d", exp_r.normal_y, got.normal_y);
					errors++;
				end
			end
		end
	end

	initial begin
		int hold;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				hold = 0;
				while (hold < 200) begin
					@(negedge clk);
					hold++;
				end
			end
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		@(posedge clk);
		wait (idle_cycles >= WD_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		in_t dir_pairs[N_DIR];
		int dir_chk[N_DIR];
		hit_t dir_typed[N_DIR];
		hit_t h;
		int i;
		quiet = 1'b0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		for (i = 0; i < N_DIR; i++) begin
			dir_chk[i] = CHK_NONE;
			dir_typed[i] = '0;
		end
		// 0/0 on both axes: coincident centres, zero extents, equal motion
		dir_pairs[0] = box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_chk[0] = CHK_MISS;
		// head-on along x, entry at one half
		dir_pairs[1] = box_pair(0, 0, 256, 256, 1024, 0, 1024, 0, 256, 256, 0, 0);
		h.hit = 1'b1; h.entry_time = 17'd32768; h.normal_x = NRM_NEG; h.normal_y = NRM_NONE;
		dir_typed[1] = h; dir_chk[1] = CHK_TYPED;
		// along y from above, moving down
		dir_pairs[2] = box_pair(0, 1024, 256, 256, 0, -1024, 0, 0, 256, 256, 0, 0);
		dir_pairs[3] = box_pair(0, 0, 256, 256, 256, 0, 4096, 0, 256, 256, 0, 0);
		dir_chk[3] = CHK_MISS;
		// already overlapping: negative entry
		dir_pairs[4] = box_pair(0, 0, 512, 512, 100, 100, 10, 10, 512, 512, 0, 0);
		dir_chk[4] = CHK_MISS;
		// diagonal, equal entry times: y wins
		dir_pairs[5] = box_pair(0, 0, 256, 256, 1024, 1024, 1024, 1024, 256, 256, 0, 0);
		dir_pairs[6] = box_pair(-8388608, -8388608, 4194303, 4194303, 8388607, 8388607,
			8388607, 8388607, 4194303, 4194303, -8388608, -8388608);
		dir_pairs[7] = box_pair(8388607, 8388607, 0, 0, -8388608, -8388608,
			-8388608, -8388608, 0, 0, 8388607, 8388607);
		dir_pairs[8] = box_pair(-1, -1, 4194303, 0, -1, -1, 0, 0, 0, 4194303, -1, -1);
		// zero x velocity, inside x slab
		dir_pairs[9] = box_pair(0, 0, 256, 256, 0, 2048, 0, 1024, 256, 256, 0, 0);
		// zero x velocity, outside x slab
		dir_pairs[10] = box_pair(0, 0, 256, 256, 0, 2048, 5000, 1024, 256, 256, 0, 0);
		dir_chk[10] = CHK_MISS;
		// touching at t exactly 1
		dir_pairs[11] = box_pair(0, 0, 256, 256, 512, 0, 1024, 0, 256, 256, 0, 0);
		dir_chk[11] = CHK_MISS;
		// moving away on x with B moving
		dir_pairs[12] = box_pair(0, 0, 256, 256, 0, 0, 1024, 0, 256, 256, 2048, 0);
		dir_pairs[13] = box_pair(0, 0, 256, 256, 0, 0, 1024, 0, 256, 256, -1024, 0);
		// rounding toward minus infinity
		dir_pairs[14] = box_pair(0, 0, 1, 1, 3, -7, 2, -1, 0, 0, 0, 0);
		dir_pairs[15] = box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_chk[15] = CHK_MISS;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (i = 0; i < N_DIR; i++)
			send_pair(dir_pairs[i], dir_chk[i], dir_typed[i]);
		hold_off_req = 1'b1;
		for (i = 0; i < N_RAND; i++) begin
			if (i == N_RAND - 300)
				quiet = 1'b1;
			send_pair(random_pair($urandom_range(0, 9) < 8), CHK_NONE, dir_typed[0]);
		end
		s_tvalid <= 1'b0;
		wait (expected_hits.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
